@@ hdl/nnls_pkg.sv @@
// nnls_pkg: shared types, codes and fixed widths of the nearest neighbor scan
// used by every module of the block and by the checker; no dependencies
package nnls_pkg;

    localparam int COORD_W = 16;
    localparam int SQ_W    = 32;
    localparam int SUM_W   = 38;
    localparam int INDEX_W = 16;
    localparam int DIM_W   = 7;

    // configuration port
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 3;
    localparam int WORD_W        = ADDR_W - 2;
    localparam int REG_DIMENSION = 0;
    localparam logic [DIM_W-1:0] DIM_RESET = 7'd1;

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_POINT  = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_SATURATED = 2'd2;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [COORD_W-1:0] coordinate;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] nearest_index;
        logic [SUM_W-1:0]   nearest_distance_sq;
        logic [1:0]         status;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        logic       last;
    } stage_ctl_t;

endpackage

@@ hdl/nearest_neighbor_linear_scan.sv @@
// nearest_neighbor_linear_scan: top level, configuration register and pipeline wiring
// depends on nnls_pkg, nnls_front, nnls_dist, nnls_acc
//
//   channel   handshake                  word
//   item      item_valid / item_ready    nnls_pkg::item_t (operation, coordinate)
//   result    result_valid / result_ready nnls_pkg::result_t (index, distance, status)
//   config    psel / penable / pready    dimension at byte address 0
//
// one word per cycle unless stalled; finish word path: s1, s2, result register
// three register stages: query memory read, subtract and square, accumulate and compare
// the only stall is a finish word reaching the last stage while the previous result waits
// reset clears positions and scan state; the query memory holds no reset value
module nearest_neighbor_linear_scan #(
    parameter int MAX_DIM    = 64,
    parameter int MAX_POINTS = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  nnls_pkg::item_t               item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output nnls_pkg::result_t             result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nnls_pkg::ADDR_W-1:0]   paddr,
    input  logic [nnls_pkg::DATA_W-1:0]   pwdata,
    output logic [nnls_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import nnls_pkg::*;

    logic [DIM_W-1:0]          dimension_reg;
    logic                      dim_sel;
    logic                      advance;
    stage_ctl_t                s1_ctl, s2_ctl;
    logic signed [COORD_W-1:0] s1_coord, s1_query;
    logic [SQ_W-1:0]           s2_sq;

    assign dim_sel = (paddr[ADDR_W-1:2] == WORD_W'(REG_DIMENSION));
    assign pready  = 1'b1;
    assign prdata  = dim_sel ? DATA_W'(dimension_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg <= DIM_RESET;
        end
        else if (psel && penable && pwrite && pready && dim_sel)
        begin
            dimension_reg <= pwdata[DIM_W-1:0];
        end
    end

    assign item_ready = advance;

    nnls_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item),
        .dimension  (dimension_reg),
        .s1_ctl     (s1_ctl),
        .s1_coord   (s1_coord),
        .s1_query   (s1_query)
    );

    nnls_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .s1_ctl   (s1_ctl),
        .s1_coord (s1_coord),
        .s1_query (s1_query),
        .s2_ctl   (s2_ctl),
        .s2_sq    (s2_sq)
    );

    nnls_acc #(
        .MAX_POINTS (MAX_POINTS)
    ) u_acc (
        .clk          (clk),
        .rst_n        (rst_n),
        .s2_ctl       (s2_ctl),
        .s2_sq        (s2_sq),
        .result_ready (result_ready),
        .advance      (advance),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ hdl/nnls_front.sv @@
// nnls_front: position tracking, query coordinate memory and first stage register
// depends on nnls_pkg
module nnls_front #(
    parameter int MAX_DIM = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              item_valid,
    input  nnls_pkg::item_t                   item,
    input  logic [nnls_pkg::DIM_W-1:0]        dimension,
    output nnls_pkg::stage_ctl_t              s1_ctl,
    output logic signed [nnls_pkg::COORD_W-1:0] s1_coord,
    output logic signed [nnls_pkg::COORD_W-1:0] s1_query
);
    import nnls_pkg::*;

    localparam int PW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int EW0 = $clog2(MAX_DIM + 1);
    localparam int EW  = (EW0 > DIM_W) ? EW0 : DIM_W;

    logic [PW-1:0] qpos_reg, qpos_next;
    logic [PW-1:0] cpos_reg, cpos_next;
    logic [EW-1:0] dim_ext, eff_dim, qaddr_ext, qinc_ext;
    logic          accept, point_last;
    stage_ctl_t    s1_ctl_reg;
    logic signed [COORD_W-1:0] s1_coord_reg, s1_query_reg;
    logic signed [COORD_W-1:0] qmem [MAX_DIM];

    assign accept = advance && item_valid;

    always_comb
    begin
        dim_ext = EW'(dimension);
        priority if (dim_ext == '0)
        begin
            eff_dim = EW'(1);
        end
        else if (dim_ext > EW'(MAX_DIM))
        begin
            eff_dim = EW'(MAX_DIM);
        end
        else
        begin
            eff_dim = dim_ext;
        end
    end

    // a stale position past a shrunk dimension restarts at zero
    always_comb
    begin
        qaddr_ext  = (EW'(qpos_reg) >= eff_dim) ? '0 : EW'(qpos_reg);
        qinc_ext   = qaddr_ext + EW'(1);
        point_last = (EW'(cpos_reg) + EW'(1)) >= eff_dim;
    end

    always_comb
    begin
        qpos_next = qpos_reg;
        cpos_next = cpos_reg;
        if (accept)
        begin
            unique case (item.operation)
                OP_QUERY:
                begin
                    qpos_next = (qinc_ext >= eff_dim) ? '0 : qinc_ext[PW-1:0];
                end
                OP_POINT:
                begin
                    cpos_next = point_last ? '0 : cpos_reg + PW'(1);
                end
                OP_FINISH:
                begin
                    cpos_next = '0;
                end
                default:
                begin
                    cpos_next = cpos_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qpos_reg   <= '0;
            cpos_reg   <= '0;
            s1_ctl_reg <= '0;
        end
        else
        begin
            qpos_reg <= qpos_next;
            cpos_reg <= cpos_next;
            if (advance)
            begin
                s1_ctl_reg.valid <= accept;
                s1_ctl_reg.op    <= item.operation;
                s1_ctl_reg.last  <= point_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (item.operation == OP_QUERY))
        begin
            qmem[qaddr_ext[PW-1:0]] <= item.coordinate;
        end
        if (advance)
        begin
            s1_query_reg <= qmem[cpos_reg];
            s1_coord_reg <= item.coordinate;
        end
    end

    assign s1_ctl   = s1_ctl_reg;
    assign s1_coord = s1_coord_reg;
    assign s1_query = s1_query_reg;

endmodule

@@ hdl/nnls_dist.sv @@
// nnls_dist: squared difference of one coordinate against the query
// depends on nnls_pkg
module nnls_dist (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  nnls_pkg::stage_ctl_t                s1_ctl,
    input  logic signed [nnls_pkg::COORD_W-1:0] s1_coord,
    input  logic signed [nnls_pkg::COORD_W-1:0] s1_query,
    output nnls_pkg::stage_ctl_t                s2_ctl,
    output logic [nnls_pkg::SQ_W-1:0]           s2_sq
);
    import nnls_pkg::*;

    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]        mag_full;
    logic [COORD_W-1:0]      mag;
    logic [SQ_W-1:0]         sq;
    stage_ctl_t              s2_ctl_reg;
    logic [SQ_W-1:0]         s2_sq_reg;

    // magnitude of a 17-bit difference never exceeds 16 bits
    always_comb
    begin
        diff     = {s1_coord[COORD_W-1], s1_coord} - {s1_query[COORD_W-1], s1_query};
        mag_full = diff[COORD_W] ? unsigned'(-diff) : unsigned'(diff);
        mag      = mag_full[COORD_W-1:0];
        sq       = SQ_W'(mag) * SQ_W'(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
        end
        else if (advance)
        begin
            s2_ctl_reg <= s1_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_sq_reg <= sq;
        end
    end

    assign s2_ctl = s2_ctl_reg;
    assign s2_sq  = s2_sq_reg;

endmodule

@@ hdl/nnls_acc.sv @@
// nnls_acc: running sum, best point tracking and result register
// depends on nnls_pkg
module nnls_acc #(
    parameter int MAX_POINTS = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  nnls_pkg::stage_ctl_t        s2_ctl,
    input  logic [nnls_pkg::SQ_W-1:0]   s2_sq,
    input  logic                        result_ready,
    output logic                        advance,
    output logic                        result_valid,
    output nnls_pkg::result_t           result
);
    import nnls_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = $clog2(MAX_POINTS);

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0] best_reg, best_next;
    logic [IW-1:0]    best_idx_reg, best_idx_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             found_reg, found_next;
    logic             ovf_reg, ovf_next;
    logic             result_valid_reg, result_valid_next;
    result_t          result_reg, result_next;

    logic             finish_here, point_here;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_sat;

    assign finish_here = s2_ctl.valid && (s2_ctl.op == OP_FINISH);
    assign point_here  = s2_ctl.valid && (s2_ctl.op == OP_POINT);
    // only a finish word waiting on a full result register holds the pipe
    assign advance     = !(finish_here && result_valid_reg && !result_ready);

    always_comb
    begin
        sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(s2_sq);
        sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    end

    always_comb
    begin
        sum_next          = sum_reg;
        best_next         = best_reg;
        best_idx_next     = best_idx_reg;
        count_next        = count_reg;
        found_next        = found_reg;
        ovf_next          = ovf_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;

        if (advance && point_here)
        begin
            if (s2_ctl.last)
            begin
                sum_next = '0;
                if (count_reg >= CW'(MAX_POINTS))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    // strict compare keeps the earlier point on a tie
                    if (!found_reg || (sum_sat < best_reg))
                    begin
                        best_next     = sum_sat;
                        best_idx_next = count_reg[IW-1:0];
                        found_next    = 1'b1;
                    end
                    count_next = count_reg + CW'(1);
                end
            end
            else
            begin
                sum_next = sum_sat;
            end
        end

        if (advance && finish_here)
        begin
            if (found_reg)
            begin
                result_next.nearest_index       = INDEX_W'(best_idx_reg);
                result_next.nearest_distance_sq = best_reg;
                result_next.status              = ovf_reg ? STATUS_SATURATED : STATUS_OK;
            end
            else
            begin
                result_next.nearest_index       = '0;
                result_next.nearest_distance_sq = '0;
                result_next.status              = STATUS_EMPTY;
            end
            result_valid_next = 1'b1;
            sum_next          = '0;
            best_next         = '0;
            best_idx_next     = '0;
            count_next        = '0;
            found_next        = 1'b0;
            ovf_next          = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg          <= '0;
            best_reg         <= '0;
            best_idx_reg     <= '0;
            count_reg        <= '0;
            found_reg        <= 1'b0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg          <= sum_next;
            best_reg         <= best_next;
            best_idx_reg     <= best_idx_next;
            count_reg        <= count_next;
            found_reg        <= found_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ hdl/nnls_checker.sv @@
// nnls_checker: port level checks on the item and result channels, bound to the top level
// depends on nnls_pkg and nearest_neighbor_linear_scan
module nnls_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input nnls_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_ready,
    input nnls_pkg::result_t result
);
    import nnls_pkg::*;

    // an offered item word holds until taken
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("item word changed while stalled");

    // a waiting result word holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // an empty scan reports zero index and distance
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == STATUS_EMPTY) |->
            (result.nearest_index == '0) && (result.nearest_distance_sq == '0))
        else $error("empty scan with nonzero fields");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == STATUS_OK) || (result.status == STATUS_EMPTY)
            || (result.status == STATUS_SATURATED))
        else $error("undefined status code");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result valid after reset");

endmodule

bind nearest_neighbor_linear_scan nnls_checker u_checker (.*);

@@ verif/tb_nearest_neighbor_linear_scan.sv @@
// tb_nearest_neighbor_linear_scan: self-checking bench for the nearest neighbor scan, with
// a small tracker class that predicts each finish result; depends on nnls_pkg and the block
module tb_nearest_neighbor_linear_scan;
    import nnls_pkg::*;

    localparam int MAX_DIM       = 64;
    localparam int MAX_POINTS    = 65536;
    localparam int RANDOM_WORDS  = 1600;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 1000;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [ADDR_W-1:0] DIM_ADDR = ADDR_W'(4 * REG_DIMENSION);

    typedef logic signed [COORD_W-1:0] coord_t;

    class nearest_tracker #(int DIMS = 64, int POINTS = 65536);
        coord_t           query_store [DIMS];
        int unsigned      query_pos;
        int unsigned      coord_pos;
        int unsigned      point_count;
        logic [SUM_W-1:0] partial_sum;
        logic [SUM_W-1:0] best_dist;
        logic [INDEX_W-1:0] best_idx;
        bit               found;
        bit               saturated;
        logic [DIM_W-1:0] dim_reg;
        result_t          pending_reports [$];
        int               mismatches;

        function new();
            foreach (query_store[k])
                query_store[k] = '0;
            query_pos = 0;
            dim_reg = DIM_RESET;
            mismatches = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            coord_pos = 0;
            point_count = 0;
            partial_sum = '0;
            best_dist = '0;
            best_idx = '0;
            found = 0;
            saturated = 0;
        endfunction

        // dimension in use: zero acts as one, oversize clamps
        function int unsigned span();
            if (dim_reg == 0)
                return 1;
            if (dim_reg > DIMS)
                return DIMS;
            return dim_reg;
        endfunction

        function void set_dimension(logic [DIM_W-1:0] value);
            dim_reg = value;
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        function void take_word(item_t w);
            int unsigned        d;
            int unsigned        p;
            logic signed [16:0] diff;
            logic signed [33:0] wide_diff;
            logic [33:0]        sq;
            logic [SUM_W:0]     total;
            result_t            r;
            d = span();
            case (op_t'(w.operation))
                OP_QUERY:
                begin
                    p = (query_pos >= d) ? 0 : query_pos;
                    query_store[p % DIMS] = w.coordinate;
                    p++;
                    query_pos = (p >= d) ? 0 : p;
                end
                OP_POINT:
                begin
                    diff = {w.coordinate[COORD_W-1], w.coordinate}
                         - {query_store[coord_pos % DIMS][COORD_W-1],
                            query_store[coord_pos % DIMS]};
                    wide_diff = diff;
                    sq = wide_diff * wide_diff;
                    total = {1'b0, partial_sum} + sq;
                    partial_sum = total[SUM_W] ? '1 : total[SUM_W-1:0];
                    if (coord_pos + 1 >= d)
                    begin
                        if (point_count >= POINTS)
                            saturated = 1;
                        else
                        begin
                            // strictly smaller only, the earlier point keeps a tie
                            if (!found || partial_sum < best_dist)
                            begin
                                best_dist = partial_sum;
                                best_idx = INDEX_W'(point_count);
                                found = 1;
                            end
                            point_count++;
                        end
                        partial_sum = '0;
                        coord_pos = 0;
                    end
                    else
                        coord_pos++;
                end
                OP_FINISH:
                begin
                    if (!found)
                    begin
                        r.nearest_index = '0;
                        r.nearest_distance_sq = '0;
                        r.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        r.nearest_index = best_idx;
                        r.nearest_distance_sq = best_dist;
                        r.status = saturated ? STATUS_SATURATED : STATUS_OK;
                    end
                    pending_reports.insert(pending_reports.size(), r);
                    clear_scan();
                end
                default:
                begin
                end
            endcase
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task match_report(result_t got);
            result_t want;
            if (pending_reports.size() == 0)
            begin
                report($sformatf("result with nothing expected: index %0d distance %0d status %0d",
                                 got.nearest_index, got.nearest_distance_sq, got.status));
                return;
            end
            want = pending_reports.pop_front();
            if (got.nearest_index !== want.nearest_index)
                report($sformatf("nearest_index %0d, expected %0d",
                                 got.nearest_index, want.nearest_index));
            if (got.nearest_distance_sq !== want.nearest_distance_sq)
                report($sformatf("nearest_distance_sq %0d, expected %0d",
                                 got.nearest_distance_sq, want.nearest_distance_sq));
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    item_t               item = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    result_t             result;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    bit                  steady = 1'b0;
    int                  words_sent = 0;
    int                  stall_cycles = 0;
    nearest_tracker #(MAX_DIM, MAX_POINTS) tracker;

    nearest_neighbor_linear_scan #(
        .MAX_DIM    (MAX_DIM),
        .MAX_POINTS (MAX_POINTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        result_ready <= steady || ($urandom_range(99) >= 6);

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            tracker.match_report(result);
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("tb_nearest_neighbor_linear_scan: errors");
        $finish;
    end

    function automatic item_t make_word(logic [1:0] op, coord_t c);
        item_t w;
        w.operation = op;
        w.coordinate = c;
        return w;
    endfunction

    // extremes, values close to the query, or anything
    function automatic coord_t pick_coord(coord_t anchor);
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2, 3, 4: return coord_t'(anchor + $urandom_range(6) - 3);
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic send_item(item_t w);
        while (!steady && $urandom_range(99) < 6)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        tracker.take_word(w);
        if (w.operation != OP_UNUSED)
            words_sent++;
    endtask

    // hold off words until every report is back and the pipeline is empty
    task automatic drain();
        item_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_dimension(logic [DIM_W-1:0] value);
        paddr <= DIM_ADDR;
        pwdata <= DATA_W'(value);
        pwrite <= 1'b1;
        psel <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // read back
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[DIM_W-1:0] !== value)
            tracker.report($sformatf("dimension reads %0d, written %0d",
                                     prdata[DIM_W-1:0], value));
        psel <= 1'b0;
        penable <= 1'b0;
        tracker.set_dimension(value);
    endtask

    initial
    begin
        int unsigned      d;
        int               phase;
        int               n_pts;
        int               j;
        int               k;
        int               cut;
        int               start_count;
        bit               have_prev;
        bit               tie;
        bit               extreme;
        coord_t           c;
        coord_t           prev_pt [MAX_DIM];
        logic [DIM_W-1:0] dim_val;

        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty scan, extremes, ties, ignored code, dimension zero,
        // query wrap, partial point, dimension shrunk mid point
        send_item(make_word(OP_FINISH, 16'sh0000));
        send_item(make_word(OP_UNUSED, 16'sh5a5a));
        send_item(make_word(OP_QUERY, 16'sh7fff));
        send_item(make_word(OP_POINT, 16'sh8000));
        send_item(make_word(OP_POINT, 16'sh7fff));
        send_item(make_word(OP_POINT, 16'sh7fff));
        send_item(make_word(OP_FINISH, 16'sh0000));
        drain();
        program_dimension('0);
        send_item(make_word(OP_QUERY, 16'sh8000));
        send_item(make_word(OP_POINT, 16'sh0000));
        send_item(make_word(OP_FINISH, 16'shffff));
        drain();
        program_dimension(DIM_W'(3));
        send_item(make_word(OP_QUERY, 16'sh0100));
        send_item(make_word(OP_QUERY, -16'sh0100));
        send_item(make_word(OP_QUERY, 16'sh0000));
        send_item(make_word(OP_QUERY, 16'sh0001));
        send_item(make_word(OP_QUERY, -16'sh0001));
        send_item(make_word(OP_POINT, 16'sh0002));
        send_item(make_word(OP_POINT, -16'sh0003));
        send_item(make_word(OP_POINT, 16'sh0100));
        send_item(make_word(OP_POINT, 16'sh0001));
        send_item(make_word(OP_POINT, 16'sh0000));
        drain();
        program_dimension(DIM_W'(2));
        send_item(make_word(OP_POINT, 16'sh0000));
        send_item(make_word(OP_QUERY, 16'sh0005));
        send_item(make_word(OP_FINISH, 16'sh0000));

        // random scans: query, points with random content, optional partial point, finish
        start_count = words_sent;
        phase = 0;
        while (words_sent - start_count < RANDOM_WORDS)
        begin
            steady = (phase >= 10 && phase < 25);
            extreme = (phase == 1);
            have_prev = 0;
            if (phase < 3 || $urandom_range(2) == 0)
            begin
                case (phase)
                    0: dim_val = DIM_W'(MAX_DIM);
                    1: dim_val = '1;
                    2: dim_val = '0;
                    default:
                        dim_val = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(127))
                                                           : DIM_W'($urandom_range(1, 8));
                endcase
                drain();
                program_dimension(dim_val);
            end
            d = tracker.span();
            // a full query covers every position in use
            for (j = 0; j < d; j++)
                send_item(make_word(OP_QUERY,
                                    extreme ? 16'sh8000 : pick_coord(coord_t'($urandom))));
            n_pts = extreme ? 1 : (d > 16) ? $urandom_range(0, 2) : $urandom_range(0, 10);
            for (k = 0; k < n_pts; k++)
            begin
                tie = have_prev && ($urandom_range(3) == 0);
                j = 0;
                while (j < d)
                begin
                    if ($urandom_range(29) == 0)
                        send_item(make_word(OP_UNUSED, coord_t'($urandom)));
                    if (extreme)
                        c = 16'sh7fff;
                    else if (tie)
                        c = prev_pt[j];
                    else
                        c = pick_coord(tracker.query_store[j]);
                    prev_pt[j] = c;
                    send_item(make_word(OP_POINT, c));
                    j++;
                    // shrink only, so every position read stays written
                    if (j < d && $urandom_range(39) == 0)
                    begin
                        drain();
                        d = $urandom_range(1, d - 1);
                        program_dimension(DIM_W'(d));
                        have_prev = 0;
                    end
                end
                have_prev = 1;
                if ($urandom_range(19) == 0)
                    send_item(make_word(OP_QUERY, pick_coord(coord_t'($urandom))));
            end
            if (d > 1 && $urandom_range(3) == 0)
            begin
                cut = $urandom_range(1, d - 1);
                for (j = 0; j < cut; j++)
                    send_item(make_word(OP_POINT, pick_coord(tracker.query_store[j])));
            end
            send_item(make_word(OP_FINISH, coord_t'($urandom)));
            if ($urandom_range(3) == 0)
                drain();
            phase++;
        end
        steady = 1'b0;

        drain();
        if (tracker.mismatches == 0)
            $display("tb_nearest_neighbor_linear_scan: clean");
        else
            $display("tb_nearest_neighbor_linear_scan: errors");
        $finish;
    end

endmodule

@@ nearest_neighbor_linear_scan.f @@
hdl/nnls_pkg.sv
hdl/nnls_front.sv
hdl/nnls_dist.sv
hdl/nnls_acc.sv
hdl/nearest_neighbor_linear_scan.sv
hdl/nnls_checker.sv
verif/tb_nearest_neighbor_linear_scan.sv
